// ===== hw/rtl/phsd_pkg.sv =====
`timescale 1ns / 1ps

package phsd_pkg;

   // Fixed field widths of the byte stream and of the delivery record.
   localparam int unsigned SubWidth  = 4;
   localparam int unsigned OfsWidth  = 11;
   localparam int unsigned AddrWidth = 10;
   localparam int unsigned RepWidth  = 16;
   localparam int unsigned LenWidth  = 17;

   // Defaults for the top-level parameters.
   localparam int unsigned DefSubscribers = 4;
   localparam int unsigned DefMaxLen      = 1024;
   localparam int unsigned DefHdrSize     = 4;
   localparam int unsigned DefRepIdOffset = 0;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_HDR     = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_WAIT    = 3'b100
   } phase_type;

   // One input item; the lowest field sits in the lowest bits.
   typedef struct packed {
      logic                    last_flag;
      logic [SubWidth-1:0]     grant_mask;
      logic [SubWidth-1:0]     matched_mask;
      logic [7:0]              data_byte;
   } item_type;

   // One result item; the lowest field sits in the lowest bits (64 bits total).
   typedef struct packed {
      logic [SubWidth-1:0]     info_mask;
      logic [RepWidth-1:0]     info_rep_id;
      logic [OfsWidth-1:0]     info_length;
      logic                    info_valid;
      logic [7:0]              write_data;
      logic [AddrWidth-1:0]    write_address;
      logic [SubWidth-1:0]     write_enable_mask;
      logic [SubWidth-1:0]     release_mask;
      logic                    release_strobe;
      logic [SubWidth-1:0]     request_mask;
      logic                    request_strobe;
   } result_type;

endpackage

// ===== hw/rtl/phsd_parser.sv =====
`timescale 1ns / 1ps

module phsd_parser #(
   parameter int unsigned SUBSCRIBERS   = phsd_pkg::DefSubscribers,
   parameter int unsigned MAX_LEN       = phsd_pkg::DefMaxLen,
   parameter int unsigned HDR_SIZE      = phsd_pkg::DefHdrSize,
   parameter int unsigned REP_ID_OFFSET = phsd_pkg::DefRepIdOffset
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  phsd_pkg::item_type   item,
   output phsd_pkg::result_type result
);

   localparam logic [phsd_pkg::SubWidth-1:0] SubMask =
      phsd_pkg::SubWidth'((1 << SUBSCRIBERS) - 1);
   localparam logic [phsd_pkg::OfsWidth-1:0] RepHiOfs = phsd_pkg::OfsWidth'(REP_ID_OFFSET);
   localparam logic [phsd_pkg::OfsWidth-1:0] RepLoOfs =
      phsd_pkg::OfsWidth'(REP_ID_OFFSET + 1);
   localparam logic [phsd_pkg::OfsWidth-1:0] HdrEnd   = phsd_pkg::OfsWidth'(HDR_SIZE);
   localparam logic [phsd_pkg::LenWidth-1:0] MaxLen   = phsd_pkg::LenWidth'(MAX_LEN);

   phsd_pkg::phase_type                phase_ff, phase_in;
   logic [phsd_pkg::OfsWidth-1:0]      offset_ff, offset_in;
   logic [phsd_pkg::RepWidth-1:0]      rep_id_ff, rep_id_in;

   logic [phsd_pkg::SubWidth-1:0]      matched;
   logic [phsd_pkg::SubWidth-1:0]      grant;
   logic [phsd_pkg::SubWidth-1:0]      deliver;
   logic [phsd_pkg::OfsWidth-1:0]      offset_inc;

   assign matched    = item.matched_mask & SubMask;
   assign grant      = item.grant_mask & SubMask;
   assign deliver    = matched & grant;
   assign offset_inc = offset_ff + phsd_pkg::OfsWidth'(1);

   // Result and next state for the item at hand.
   always_comb begin
      result    = '0;
      phase_in  = phase_ff;
      offset_in = offset_ff;
      rep_id_in = rep_id_ff;
      case (phase_ff)
         phsd_pkg::PH_HDR: begin
            // Big-endian rep id: high byte first, then the low byte.
            if (offset_ff == RepHiOfs) begin
               rep_id_in = {item.data_byte, 8'h00};
            end else if (offset_ff == RepLoOfs) begin
               rep_id_in = {rep_id_ff[15:8], rep_id_ff[7:0] | item.data_byte};
            end
            if (offset_ff == '0) begin
               result.request_strobe = 1'b1;
               result.request_mask   = matched;
            end
            offset_in = offset_inc;
            if (offset_inc == HdrEnd) begin
               offset_in = '0;
               phase_in  = (deliver != '0) ? phsd_pkg::PH_PAYLOAD : phsd_pkg::PH_WAIT;
            end
         end
         phsd_pkg::PH_PAYLOAD: begin
            if (deliver != '0) begin
               result.write_enable_mask = deliver;
               result.write_address     = offset_ff[phsd_pkg::AddrWidth-1:0];
               result.write_data        = item.data_byte;
            end
            offset_in = offset_inc;
            // Delivery ends at the end flag or at the length limit.
            if (item.last_flag ||
                {{(phsd_pkg::LenWidth-phsd_pkg::OfsWidth){1'b0}}, offset_inc} == MaxLen) begin
               result.release_strobe = 1'b1;
               result.release_mask   = grant;
               result.info_valid     = 1'b1;
               result.info_length    = offset_inc;
               result.info_rep_id    = rep_id_ff;
               result.info_mask      = deliver;
               phase_in              = phsd_pkg::PH_WAIT;
            end
         end
         default: begin
            // Waiting for the end of the message; nothing is written.
         end
      endcase
      // The end flag always releases the grant and restarts the parser.
      if (item.last_flag) begin
         result.release_strobe = 1'b1;
         result.release_mask   = grant;
         phase_in              = phsd_pkg::PH_HDR;
         offset_in             = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= phsd_pkg::PH_HDR;
         offset_ff <= '0;
         rep_id_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         rep_id_ff <= rep_id_in;
      end
   end

endmodule

// ===== hw/rtl/payload_header_strip_and_deliver.sv =====
`timescale 1ns / 1ps

// Channel   Ports                              Contents
// -------   --------------------------------   ----------------------------------------
// request   req_tvalid/tready/tdata/tlast      one message byte with masks, end in tlast
// response  rsp_tvalid/tready/tdata            one delivery result per byte item
//
// Each item is first held in an input register and then moves on to the result
// register, where its result is presented; one item per clock is sustained while
// rsp_tready stays high. The parser state advances when an item moves from the
// input register into the result register. When the response side stalls, both
// registers fill and req_tready drops.
// Synchronous reset empties both registers and returns the parser to the header phase.

module payload_header_strip_and_deliver #(
   parameter int unsigned SUBSCRIBERS   = phsd_pkg::DefSubscribers,
   parameter int unsigned MAX_LEN       = phsd_pkg::DefMaxLen,
   parameter int unsigned HDR_SIZE      = phsd_pkg::DefHdrSize,
   parameter int unsigned REP_ID_OFFSET = phsd_pkg::DefRepIdOffset
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0], matched_mask[11:8], grant_mask[15:12]
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // request_strobe[0], request_mask[4:1], release_strobe[5], release_mask[9:6],
   // write_enable_mask[13:10], write_address[23:14], write_data[31:24],
   // info_valid[32], info_length[43:33], info_rep_id[59:44], info_mask[63:60]
   output logic [63:0] rsp_tdata
);

   logic                 in_valid_ff;
   phsd_pkg::item_type   in_item_ff;
   logic                 out_valid_ff;
   phsd_pkg::result_type out_data_ff;
   phsd_pkg::result_type result;
   logic                 advance;

   // The input register moves on whenever the result register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   phsd_parser #(
      .SUBSCRIBERS   (SUBSCRIBERS),
      .MAX_LEN       (MAX_LEN),
      .HDR_SIZE      (HDR_SIZE),
      .REP_ID_OFFSET (REP_ID_OFFSET)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= {req_tlast, req_tdata};
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule
